### design/psch_pkg.sv
// ----------------------------------------------------------------------------
// psch_pkg
// Types and constants shared by the preemptive priority scheduler.
// ----------------------------------------------------------------------------
package psch_pkg;

  localparam int MAX_PROCS = 16;
  localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);
  localparam int TIME_W    = 21;
  localparam int SUM_W     = 25;

  typedef struct packed {
    logic [15:0] proc_id;
    logic [15:0] arrival_time;
    logic [15:0] burst_time;
    logic [7:0]  prio_value;
    logic        last_proc;
  } in_item_t;

  typedef struct packed {
    logic [15:0]       out_id;
    logic [TIME_W-1:0] completion_time;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic [SUM_W-1:0]  total_turnaround;
    logic [SUM_W-1:0]  total_waiting;
    logic              overflow;
    logic              last_result;
  } out_item_t;

  // Fields read on every scan pass
  typedef struct packed {
    logic [15:0] arrival;
    logic [7:0]  prio;
    logic [15:0] remaining;
  } scan_word_t;

  // Fields read only for the best entry and at result time
  typedef struct packed {
    logic [15:0] id;
    logic [15:0] burst;
  } info_word_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] best_idx;
    logic [7:0]       best_prio;
    logic [15:0]      best_rem;
    logic [15:0]      best_arr;
    logic [15:0]      best_burst;
    logic             fut_found;
    logic [15:0]      fut_arr;
  } scan_res_t;

endpackage

### design/psch_ram.sv
// ----------------------------------------------------------------------------
// psch_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module psch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### design/psch_scan.sv
// ----------------------------------------------------------------------------
// psch_scan
// Compare unit stepped over the stored processes, one entry a cycle: keeps
// the ready entry of smallest priority and the earliest future arrival.
// ----------------------------------------------------------------------------
module psch_scan (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          clr,
  input  logic                          vld,
  input  logic [psch_pkg::IDX_W-1:0]    idx,
  input  psch_pkg::scan_word_t          sw,
  input  psch_pkg::info_word_t          iw,
  input  logic [psch_pkg::TIME_W-1:0]   now,
  output psch_pkg::scan_res_t           res
);

  psch_pkg::scan_res_t res_r;
  logic                live_w;
  logic                ready_w;
  logic                future_w;
  logic                take_w;
  logic                take_fut_w;
  logic [psch_pkg::TIME_W-1:0] arr_ext_w;

  assign arr_ext_w  = psch_pkg::TIME_W'(sw.arrival);
  assign live_w     = (sw.remaining != 16'd0);
  assign ready_w    = live_w && (arr_ext_w <= now);
  assign future_w   = live_w && (arr_ext_w > now);
  // strict compare: on equal priority the earlier entry stays
  assign take_w     = ready_w && (!res_r.found || (sw.prio < res_r.best_prio));
  assign take_fut_w = future_w && (!res_r.fut_found || (sw.arrival < res_r.fut_arr));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.found     <= 1'b0;
      res_r.fut_found <= 1'b0;
    end else if (clr) begin
      res_r.found     <= 1'b0;
      res_r.fut_found <= 1'b0;
    end else if (vld) begin
      if (take_w) begin
        res_r.found      <= 1'b1;
        res_r.best_idx   <= idx;
        res_r.best_prio  <= sw.prio;
        res_r.best_rem   <= sw.remaining;
        res_r.best_arr   <= sw.arrival;
        res_r.best_burst <= iw.burst;
      end
      if (take_fut_w) begin
        res_r.fut_found <= 1'b1;
        res_r.fut_arr   <= sw.arrival;
      end
    end
  end

  assign res = res_r;

endmodule

### design/preemptive_priority_scheduler.sv
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// Loads process records, runs a preemptive priority schedule event by event
// and returns completion, turnaround and waiting time for each process.
// ----------------------------------------------------------------------------
// Loading: one item a cycle, no result until the item marked last.
// Run: each scheduling event is one scan of the n stored entries plus an
//   update (ST_DECIDE, ST_ADV, ST_FIN1, ST_FIN2); a run has at most 2n events.
// Results: n items, each through ST_ORD, ST_OCALC, ST_OWAIT and ST_OHOLD, plus any stall on the output.
// Reset: synchronous, active low; clears counters, sums and flags. The
//   record stores are not reset and need no clearing pass.
module preemptive_priority_scheduler (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  psch_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output psch_pkg::out_item_t  out_data
);

  typedef enum logic [9:0] {
    ST_LOAD   = 10'b0000000001,
    ST_SCAN   = 10'b0000000010,
    ST_DECIDE = 10'b0000000100,
    ST_ADV    = 10'b0000001000,
    ST_FIN1   = 10'b0000010000,
    ST_FIN2   = 10'b0000100000,
    ST_ORD    = 10'b0001000000,
    ST_OCALC  = 10'b0010000000,
    ST_OWAIT  = 10'b0100000000,
    ST_OHOLD  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [psch_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [psch_pkg::CNT_W-1:0]  done_r, done_nxt;
  logic [psch_pkg::CNT_W-1:0]  idx_r, idx_nxt;
  logic [psch_pkg::TIME_W-1:0] now_r, now_nxt;
  logic [psch_pkg::SUM_W-1:0]  sum_tat_r, sum_tat_nxt;
  logic [psch_pkg::SUM_W-1:0]  sum_wt_r, sum_wt_nxt;
  logic                        drop_r, drop_nxt;
  logic                        rd_vld_r;
  logic [psch_pkg::IDX_W-1:0]  rd_idx_r;
  logic [15:0]                 step_r, step_nxt;
  logic [psch_pkg::TIME_W-1:0] tat_r, tat_nxt;
  logic [15:0]                 obur_r, obur_nxt;
  logic                        out_vld_r, out_vld_nxt;
  psch_pkg::out_item_t         out_r, out_nxt;

  // RAM ports
  logic                        sa_we;
  logic [psch_pkg::IDX_W-1:0]  sa_waddr;
  psch_pkg::scan_word_t        sa_wdata, sa_rdata;
  logic                        ib_we;
  psch_pkg::info_word_t        ib_wdata, ib_rdata;
  logic                        fn_we;
  logic [psch_pkg::TIME_W-1:0] fn_rdata;
  logic [psch_pkg::IDX_W-1:0]  raddr;

  psch_pkg::scan_res_t         sres;
  logic                        scan_clr;

  logic [15:0]                 bt_fix_w;
  logic [psch_pkg::TIME_W-1:0] delta_w;
  logic [15:0]                 new_rem_w;
  logic                        last_out_w;

  assign raddr    = idx_r[psch_pkg::IDX_W-1:0];
  assign bt_fix_w = (in_data.burst_time == 16'd0) ? 16'd1 : in_data.burst_time;
  assign delta_w  = psch_pkg::TIME_W'(sres.fut_arr) - now_r;
  assign new_rem_w = sres.best_rem - step_r;
  assign last_out_w = ((idx_r + psch_pkg::CNT_W'(1)) == count_r);
  assign scan_clr = (state_r == ST_SCAN) && (idx_r == '0);

  psch_ram #(
    .WIDTH ($bits(psch_pkg::scan_word_t)),
    .DEPTH (psch_pkg::MAX_PROCS)
  ) u_scan_ram (
    .clk   (clk),
    .we    (sa_we),
    .waddr (sa_waddr),
    .wdata (sa_wdata),
    .raddr (raddr),
    .rdata (sa_rdata)
  );

  psch_ram #(
    .WIDTH ($bits(psch_pkg::info_word_t)),
    .DEPTH (psch_pkg::MAX_PROCS)
  ) u_info_ram (
    .clk   (clk),
    .we    (ib_we),
    .waddr (count_r[psch_pkg::IDX_W-1:0]),
    .wdata (ib_wdata),
    .raddr (raddr),
    .rdata (ib_rdata)
  );

  psch_ram #(
    .WIDTH (psch_pkg::TIME_W),
    .DEPTH (psch_pkg::MAX_PROCS)
  ) u_finish_ram (
    .clk   (clk),
    .we    (fn_we),
    .waddr (sres.best_idx),
    .wdata (now_r),
    .raddr (raddr),
    .rdata (fn_rdata)
  );

  psch_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (scan_clr),
    .vld   (rd_vld_r),
    .idx   (rd_idx_r),
    .sw    (sa_rdata),
    .iw    (ib_rdata),
    .now   (now_r),
    .res   (sres)
  );

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    done_nxt    = done_r;
    idx_nxt     = idx_r;
    now_nxt     = now_r;
    sum_tat_nxt = sum_tat_r;
    sum_wt_nxt  = sum_wt_r;
    drop_nxt    = drop_r;
    step_nxt    = step_r;
    tat_nxt     = tat_r;
    obur_nxt    = obur_r;
    out_vld_nxt = out_vld_r;
    out_nxt     = out_r;
    sa_we       = 1'b0;
    sa_waddr    = count_r[psch_pkg::IDX_W-1:0];
    sa_wdata    = '{arrival: in_data.arrival_time, prio: in_data.prio_value,
                    remaining: bt_fix_w};
    ib_we       = 1'b0;
    ib_wdata    = '{id: in_data.proc_id, burst: bt_fix_w};
    fn_we       = 1'b0;

    case (state_r)
      ST_LOAD: begin
        if (in_valid) begin
          if (count_r < psch_pkg::CNT_W'(psch_pkg::MAX_PROCS)) begin
            sa_we     = 1'b1;
            ib_we     = 1'b1;
            count_nxt = count_r + psch_pkg::CNT_W'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_data.last_proc) begin
            idx_nxt   = '0;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // read data arrives in the cycle after the address
        if (idx_r == count_r) begin
          idx_nxt   = '0;
          state_nxt = ST_DECIDE;
        end else begin
          idx_nxt = idx_r + psch_pkg::CNT_W'(1);
        end
      end
      ST_DECIDE: begin
        if (sres.found) begin
          if (sres.fut_found && (delta_w < psch_pkg::TIME_W'(sres.best_rem))) begin
            step_nxt = delta_w[15:0];
          end else begin
            step_nxt = sres.best_rem;
          end
          state_nxt = ST_ADV;
        end else begin
          // nothing ready: idle until the next arrival
          now_nxt   = psch_pkg::TIME_W'(sres.fut_arr);
          state_nxt = ST_SCAN;
        end
      end
      ST_ADV: begin
        now_nxt  = now_r + psch_pkg::TIME_W'(step_r);
        sa_we    = 1'b1;
        sa_waddr = sres.best_idx;
        sa_wdata = '{arrival: sres.best_arr, prio: sres.best_prio, remaining: new_rem_w};
        if (new_rem_w == 16'd0) begin
          done_nxt  = done_r + psch_pkg::CNT_W'(1);
          state_nxt = ST_FIN1;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_FIN1: begin
        fn_we     = 1'b1;
        tat_nxt   = now_r - psch_pkg::TIME_W'(sres.best_arr);
        state_nxt = ST_FIN2;
      end
      ST_FIN2: begin
        sum_tat_nxt = sum_tat_r + psch_pkg::SUM_W'(tat_r);
        sum_wt_nxt  = sum_wt_r + psch_pkg::SUM_W'(tat_r - psch_pkg::TIME_W'(sres.best_burst));
        if (done_r == count_r) begin
          idx_nxt   = '0;
          state_nxt = ST_ORD;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_ORD: begin
        state_nxt = ST_OCALC;
      end
      ST_OCALC: begin
        out_nxt.out_id          = ib_rdata.id;
        out_nxt.completion_time = fn_rdata;
        out_nxt.turnaround      = fn_rdata - psch_pkg::TIME_W'(sa_rdata.arrival);
        obur_nxt                = ib_rdata.burst;
        state_nxt               = ST_OWAIT;
      end
      ST_OWAIT: begin
        out_nxt.waiting          = out_r.turnaround - psch_pkg::TIME_W'(obur_r);
        out_nxt.total_turnaround = last_out_w ? sum_tat_r : '0;
        out_nxt.total_waiting    = last_out_w ? sum_wt_r : '0;
        out_nxt.overflow         = drop_r;
        out_nxt.last_result      = last_out_w;
        out_vld_nxt              = 1'b1;
        state_nxt                = ST_OHOLD;
      end
      ST_OHOLD: begin
        if (out_ready) begin
          out_vld_nxt = 1'b0;
          if (last_out_w) begin
            count_nxt   = '0;
            done_nxt    = '0;
            idx_nxt     = '0;
            now_nxt     = '0;
            sum_tat_nxt = '0;
            sum_wt_nxt  = '0;
            drop_nxt    = 1'b0;
            state_nxt   = ST_LOAD;
          end else begin
            idx_nxt   = idx_r + psch_pkg::CNT_W'(1);
            state_nxt = ST_ORD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      count_r   <= '0;
      done_r    <= '0;
      idx_r     <= '0;
      now_r     <= '0;
      sum_tat_r <= '0;
      sum_wt_r  <= '0;
      drop_r    <= 1'b0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      done_r    <= done_nxt;
      idx_r     <= idx_nxt;
      now_r     <= now_nxt;
      sum_tat_r <= sum_tat_nxt;
      sum_wt_r  <= sum_wt_nxt;
      drop_r    <= drop_nxt;
      rd_vld_r  <= (state_r == ST_SCAN) && (idx_r < count_r);
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= idx_r[psch_pkg::IDX_W-1:0];
    step_r   <= step_nxt;
    tat_r    <= tat_nxt;
    obur_r   <= obur_nxt;
    out_r    <= out_nxt;
  end

  assign in_ready  = (state_r == ST_LOAD);
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule
